>>> hdl/dao_pkg.sv
package dao_pkg;

	// Register indexes on the configuration port
	typedef enum logic [2:0] {
		REG_BAR_SUB   = 3'd0,
		REG_BAR_FUND  = 3'd1,
		REG_BAR_OCT   = 3'd2,
		REG_BAR_MIX2  = 3'd3,
		REG_BAR_MIX3  = 3'd4,
		REG_MORPH     = 3'd5,
		REG_DRIVE     = 3'd6
	} reg_idx_t;

	localparam int NUM_PARTIALS = 8;
	localparam int NUM_BARS     = 5;

	// Partial tag travelling with a word through the shared units
	typedef struct packed {
		logic       valid;
		logic [2:0] idx;
	} tag_t;

	typedef logic [19:0] mult_t;

	// Partial frequency multipliers, Q16
	localparam mult_t MULT_Q16 [NUM_PARTIALS] = '{
		20'd32768, 20'd65536, 20'd98304, 20'd131072,
		20'd196608, 20'd262144, 20'd330281, 20'd524288
	};

	// Drawbar register feeding each partial
	localparam reg_idx_t BAR_OF [NUM_PARTIALS] = '{
		REG_BAR_SUB, REG_BAR_FUND, REG_BAR_MIX2, REG_BAR_OCT,
		REG_BAR_MIX3, REG_BAR_MIX3, REG_BAR_MIX2, REG_BAR_MIX3
	};

	// Sine series coefficients, Q28
	localparam logic signed [31:0] SIN_C0 = 32'sd43068;
	localparam logic signed [31:0] SIN_C1 = -32'sd1256744;
	localparam logic signed [31:0] SIN_C2 = 32'sd21392326;
	localparam logic signed [31:0] SIN_C3 = -32'sd173399667;
	localparam logic signed [31:0] SIN_C4 = 32'sd421657428;

	localparam logic [28:0] ONE_Q28 = 29'd268435456;

	// Reciprocals: floor(n/1023) = (n*R1023)>>37, floor(t/5) = (t*R5)>>29,
	// floor(m/5115) = (m*R5115)>>54 for m below 2^41
	localparam logic [27:0] R1023 = 28'd134348929;
	localparam logic [26:0] R5    = 27'd107374183;
	localparam logic [41:0] R5115 = 42'd3521876541444;

	localparam logic [45:0] SAT_LIM   = 46'(64'd40920 * ((64'd1 << 28) + 64'd1));
	localparam logic [16:0] D_ONE     = 17'd65536;

	// Signed divide by 65536, truncating toward zero
	function automatic logic signed [33:0] sdiv16(input logic signed [49:0] x);
		logic signed [49:0] t;
		t = x[49] ? (x + 50'sd65535) : x;
		return t[49:16];
	endfunction

	// One Horner step: c + trunc(p*u2/65536)
	function automatic logic signed [31:0] horner(input logic signed [31:0] p,
			input logic [16:0] u2, input logic signed [31:0] c);
		logic signed [49:0] pr;
		logic signed [33:0] sum;
		pr = p * $signed({1'b0, u2});
		sum = 34'(c) + sdiv16(pr);
		return sum[31:0];
	endfunction

	// Drawbar levels above eight count as eight
	function automatic logic [3:0] bar_clamp(input logic [3:0] b);
		return (b > 4'd8) ? 4'd8 : b;
	endfunction

endpackage

>>> hdl/dao_cell.sv
module dao_cell #(
	parameter int PHASE_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  logic [PHASE_BITS-1:0] nxt,
	input  logic [PHASE_BITS-1:0] add,
	output logic [PHASE_BITS-1:0] phase
);

	logic [PHASE_BITS-1:0] phase_q;

	// Take the neighbour's phase, advanced by whatever it brings along
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (shift) begin
			phase_q <= nxt + add;
		end
	end

	assign phase = phase_q;

endmodule

>>> hdl/dao_inc.sv
module dao_inc #(
	parameter int PHASE_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dao_pkg::tag_t         tag_in,
	input  logic [23:0]           base,
	input  logic [16:0]           d,
	output dao_pkg::tag_t         tag_out,
	output logic [PHASE_BITS-1:0] inc
);

	localparam int SH = 56 - PHASE_BITS;

	dao_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic [35:0] here_s1, next_s1, mix_s2;
	logic [41:0] plo_s3, phi_s3;
	logic [PHASE_BITS-1:0] inc_s4;
	logic [2:0] knext;
	logic [59:0] full;

	assign knext = tag_in.idx + 3'd1;
	assign full = {phi_s3, 18'd0} + 60'(plo_s3);

	// Advance tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// Blend multipliers, then scale by the base increment in two halves
	always_ff @(posedge clk) begin
		here_s1 <= dao_pkg::MULT_Q16[tag_in.idx] * (dao_pkg::D_ONE - d);
		next_s1 <= dao_pkg::MULT_Q16[knext] * d;
		mix_s2  <= here_s1 + next_s1;
		plo_s3  <= base * mix_s2[17:0];
		phi_s3  <= base * mix_s2[35:18];
		inc_s4  <= full[SH +: PHASE_BITS];
	end

	assign tag_out = tag_s4;
	assign inc = inc_s4;

endmodule

>>> hdl/dao_sine.sv
module dao_sine #(
	parameter int PHASE_BITS      = 24,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [PHASE_BITS-1:0] phase,
	input  dao_pkg::tag_t         tag_in,
	output logic signed [29:0]    sine,
	output dao_pkg::tag_t         tag_out
);

	localparam int STB = SINE_TABLE_BITS;

	dao_pkg::tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic [1:0] quad_s1, quad_s2, quad_s3, quad_s4, quad_s5, quad_s6, quad_s7;
	logic [16:0] u_s1, u_s2, u_s3, u_s4, u_s5, u_s6;
	logic [16:0] u2_s2, u2_s3, u2_s4, u2_s5;
	logic signed [31:0] p_s3, p_s4, p_s5, p_s6;
	logic signed [33:0] s_s7;
	logic signed [29:0] sine_s8;

	logic [STB-1:0] idx;
	logic [15:0] u_raw;
	logic [33:0] uu;
	logic signed [49:0] sp;
	logic [28:0] mag;

	assign idx = phase[PHASE_BITS-1 -: STB];
	assign u_raw = 16'(idx[STB-3:0]) << (18 - STB);
	assign uu = u_s1 * u_s1;
	assign sp = p_s6 * $signed({1'b0, u_s6});

	// Clamp to [0, 1]
	always_comb begin
		if (s_s7 < 0) begin
			mag = '0;
		end else if (s_s7 > 34'(dao_pkg::ONE_Q28)) begin
			mag = dao_pkg::ONE_Q28;
		end else begin
			mag = s_s7[28:0];
		end
	end

	// Advance tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
			tag_s5 <= '0;
			tag_s6 <= '0;
			tag_s7 <= '0;
			tag_s8 <= '0;
		end else begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
			tag_s8 <= tag_s7;
		end
	end

	// Fold, square, four Horner steps, last product, then clamp and sign
	always_ff @(posedge clk) begin
		quad_s1 <= idx[STB-1:STB-2];
		u_s1    <= idx[STB-2] ? (17'd65536 - {1'b0, u_raw}) : {1'b0, u_raw};
		quad_s2 <= quad_s1;
		u_s2    <= u_s1;
		u2_s2   <= uu[32:16];
		quad_s3 <= quad_s2;
		u_s3    <= u_s2;
		u2_s3   <= u2_s2;
		p_s3    <= dao_pkg::horner(dao_pkg::SIN_C0, u2_s2, dao_pkg::SIN_C1);
		quad_s4 <= quad_s3;
		u_s4    <= u_s3;
		u2_s4   <= u2_s3;
		p_s4    <= dao_pkg::horner(p_s3, u2_s3, dao_pkg::SIN_C2);
		quad_s5 <= quad_s4;
		u_s5    <= u_s4;
		u2_s5   <= u2_s4;
		p_s5    <= dao_pkg::horner(p_s4, u2_s4, dao_pkg::SIN_C3);
		quad_s6 <= quad_s5;
		u_s6    <= u_s5;
		p_s6    <= dao_pkg::horner(p_s5, u2_s5, dao_pkg::SIN_C4);
		quad_s7 <= quad_s6;
		s_s7    <= dao_pkg::sdiv16(sp);
		sine_s8 <= quad_s7[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	assign sine = sine_s8;
	assign tag_out = tag_s8;

endmodule

>>> hdl/drawbar_additive_oscillator_top.sv
// Channel   | Handshake             | Payload
// input     | in_valid / in_ready   | base_increment, lfo_level
// output    | out_valid / out_ready | audio_sample
// config    | cfg_write             | cfg_index, cfg_data
//
// An accepted word first has its morph amount worked out, then the eight partial
// phases circulate once through the 4-stage increment unit and the 8-stage sine
// pipeline, then come drive gain, saturation check, reciprocal divide and soft
// clip (the divide is skipped when the gain saturates).
// The next word is taken in the cycle after the sample is posted to the output
// register, even while it waits there; no new word is taken while one is in flight.
// Reset clears the phases and sets the registers to their defaults; a stalled
// output holds the engine in its last step.
module drawbar_additive_oscillator_top #(
	parameter int PHASE_BITS      = 24,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [23:0]        base_increment,
	input  logic signed [15:0] lfo_level,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] audio_sample,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [9:0]         cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_D0, ST_D1, ST_D2, ST_RUN, ST_MUL, ST_SAT, ST_DIV,
		ST_CUB1, ST_CUB2, ST_CUB3, ST_FIN
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic signed [31:0] audio_q;
	logic [3:0] iss_q;
	logic [2:0] acnt_q;

	logic [3:0] bar_q [dao_pkg::NUM_BARS];
	logic [9:0] morph_q, drive_q;

	logic [23:0] base_q;
	logic [15:0] lfo_q;
	logic [25:0] n1_q;
	logic [54:0] np_q;
	logic [16:0] d_q;
	logic signed [35:0] acc_q;
	logic neg_q;
	logic [45:0] mag_q;
	logic [41:0] pll_q, plh_q;
	logic [40:0] phl_q, phh_q;
	logic [28:0] ax_q, a2_q, a3_q;
	logic [24:0] qq_q;

	logic [PHASE_BITS-1:0] phase [dao_pkg::NUM_PARTIALS];
	logic [PHASE_BITS-1:0] inc;
	dao_pkg::tag_t iss_tag, inc_tag, sin_tag;
	logic signed [29:0] sine;

	logic [15:0] lsum;
	logic [17:0] dq;
	logic [3:0] bar;
	logic signed [34:0] term;
	logic [34:0] absacc;
	logic [40:0] nn;
	logic [82:0] qsum;
	logic [57:0] sq, cu;
	logic [53:0] q5;
	logic [28:0] y;
	logic [31:0] yy;
	logic out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign audio_sample = audio_q;
	assign out_free = !out_valid_q || out_ready;

	assign lsum = {~lfo_q[15], lfo_q[14:0]};
	assign dq = np_q[54:37];
	assign bar = dao_pkg::bar_clamp(bar_q[dao_pkg::BAR_OF[sin_tag.idx]]);
	assign term = $signed({1'b0, bar}) * sine;
	assign absacc = acc_q[35] ? 35'(-acc_q) : acc_q[34:0];
	assign nn = mag_q[43:3];
	assign qsum = {phh_q, 42'd0} + 83'({plh_q, 21'd0}) + 83'({phl_q, 21'd0})
		+ 83'(pll_q);
	assign sq = ax_q * ax_q;
	assign cu = a2_q * ax_q;
	assign q5 = a3_q[28:2] * dao_pkg::R5;
	assign y = ax_q - 29'(qq_q);
	assign yy = {y, 3'b000};

	assign iss_tag.valid = (state_q == ST_RUN) && !iss_q[3];
	assign iss_tag.idx = iss_q[2:0];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dao_pkg::NUM_BARS; i++) begin
				bar_q[i] <= 4'd8;
			end
			morph_q <= '0;
			drive_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index) inside
				dao_pkg::REG_BAR_SUB, dao_pkg::REG_BAR_FUND, dao_pkg::REG_BAR_OCT,
				dao_pkg::REG_BAR_MIX2, dao_pkg::REG_BAR_MIX3: begin
					bar_q[cfg_index] <= cfg_data[3:0];
				end
				dao_pkg::REG_MORPH: morph_q <= cfg_data;
				dao_pkg::REG_DRIVE: drive_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			audio_q     <= '0;
			iss_q       <= '0;
			acnt_q      <= '0;
		end else begin
			if (out_ready && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_D0;
						iss_q   <= '0;
						acnt_q  <= '0;
					end
				end
				ST_D0: state_q <= ST_D1;
				ST_D1: state_q <= ST_D2;
				ST_D2: state_q <= ST_RUN;
				ST_RUN: begin
					if (!iss_q[3]) begin
						iss_q <= iss_q + 4'd1;
					end
					if (sin_tag.valid) begin
						acnt_q <= acnt_q + 3'd1;
						if (acnt_q == 3'd7) begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: state_q <= ST_SAT;
				ST_SAT: begin
					state_q <= (mag_q >= dao_pkg::SAT_LIM) ? ST_CUB1 : ST_DIV;
				end
				ST_DIV: state_q <= ST_CUB1;
				ST_CUB1: state_q <= ST_CUB2;
				ST_CUB2: state_q <= ST_CUB3;
				ST_CUB3: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						audio_q     <= neg_q ? -$signed(yy) : $signed(yy);
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				base_q <= base_increment;
				lfo_q  <= lfo_level;
				acc_q  <= '0;
			end
			ST_D0: n1_q <= morph_q * lsum;
			ST_D1: np_q <= {n1_q, 1'b0} * dao_pkg::R1023;
			ST_D2: d_q <= (dq > 18'(dao_pkg::D_ONE)) ? dao_pkg::D_ONE : dq[16:0];
			ST_RUN: begin
				if (sin_tag.valid) begin
					acc_q <= acc_q + 36'(term);
				end
			end
			ST_MUL: begin
				neg_q <= acc_q[35];
				mag_q <= absacc * (11'd1023 + 11'(drive_q));
			end
			ST_SAT: begin
				// Split the reciprocal product of mag/8 into four partial products
				ax_q  <= dao_pkg::ONE_Q28;
				pll_q <= nn[20:0] * dao_pkg::R5115[20:0];
				plh_q <= nn[20:0] * dao_pkg::R5115[41:21];
				phl_q <= nn[40:21] * dao_pkg::R5115[20:0];
				phh_q <= nn[40:21] * dao_pkg::R5115[41:21];
			end
			ST_DIV: ax_q <= qsum[82:54];
			ST_CUB1: a2_q <= sq[56:28];
			ST_CUB2: a3_q <= cu[56:28];
			ST_CUB3: qq_q <= q5[53:29];
			default: ;
		endcase
	end

	// Increment unit: one partial issued per cycle
	dao_inc #(.PHASE_BITS(PHASE_BITS)) u_inc (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_in  (iss_tag),
		.base    (base_q),
		.d       (d_q),
		.tag_out (inc_tag),
		.inc     (inc)
	);

	// Ring of phase cells; the head feeds the sine unit, the tail takes head plus increment
	for (genvar g = 0; g < dao_pkg::NUM_PARTIALS; g++) begin : g_cell
		dao_cell #(.PHASE_BITS(PHASE_BITS)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (inc_tag.valid),
			.nxt    (phase[(g + 1) % dao_pkg::NUM_PARTIALS]),
			.add    ((g == dao_pkg::NUM_PARTIALS - 1) ? inc : '0),
			.phase  (phase[g])
		);
	end

	dao_sine #(.PHASE_BITS(PHASE_BITS), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sine (
		.clk     (clk),
		.arst_n  (arst_n),
		.phase   (phase[0]),
		.tag_in  (inc_tag),
		.sine    (sine),
		.tag_out (sin_tag)
	);

endmodule

>>> hdl/dao_chk.sv
module dao_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [23:0]        base_increment,
	input logic signed [15:0] lfo_level,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] audio_sample,
	input logic               cfg_write,
	input logic [2:0]         cfg_index,
	input logic [9:0]         cfg_data
);

	// A held sample stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(audio_sample))
		else $error("output word changed while stalled");

	// An accepted word keeps the engine busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again straight after a word");

	a_busy_long: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> ##3 !in_ready)
		else $error("engine freed too early");

	// A new sample is only posted from a busy engine
	a_post: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("sample posted without a word in flight");

endmodule

bind drawbar_additive_oscillator_top dao_chk u_dao_chk (.*);
